>>> rtl/sensor_fault_alarm_qualifier_unit_macros.svh
// assertion macros used by the checker file
`ifndef SENSOR_FAULT_ALARM_QUALIFIER_UNIT_MACROS_SVH
`define SENSOR_FAULT_ALARM_QUALIFIER_UNIT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define SFAQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfaq check failed");

// next-cycle implication, reset given by the caller
`define SFAQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfaq check failed");

`endif

>>> rtl/sfaq_pkg.sv
package sfaq_pkg;

   // register indexes
   localparam logic [2:0] REG_CHANNEL_ENABLE  = 3'd0;
   localparam logic [2:0] REG_LEAK_BASELINE   = 3'd1;
   localparam logic [2:0] REG_LEAK_THRESHOLD  = 3'd2;
   localparam logic [2:0] REG_EARTH_THRESHOLD = 3'd3;

   // channel_enable bit positions
   localparam int EN_LEAK     = 0;
   localparam int EN_NEUTRAL  = 1;
   localparam int EN_NEUT_ANA = 2;
   localparam int EN_NEUT_DIG = 3;
   localparam int EN_EARTH    = 4;
   localparam int EN_TEMP     = 5;
   localparam int EN_ESTOP    = 6;
   localparam int EN_PNC      = 7;
   localparam int EN_LID      = 8;

   // alarm flag bit positions
   localparam int FLAG_LEAK    = 0;
   localparam int FLAG_NEUTRAL = 1;
   localparam int FLAG_EARTH   = 2;
   localparam int FLAG_TEMP    = 3;
   localparam int FLAG_ESTOP   = 4;
   localparam int FLAG_PNC     = 5;
   localparam int FLAG_LID     = 6;

   // channel codes of an event
   localparam logic [2:0] CH_LEAK    = 3'd0;
   localparam logic [2:0] CH_NEUTRAL = 3'd1;
   localparam logic [2:0] CH_EARTH   = 3'd2;
   localparam logic [2:0] CH_TEMP    = 3'd3;
   localparam logic [2:0] CH_ESTOP   = 3'd4;
   localparam logic [2:0] CH_LID     = 3'd5;
   localparam int NUM_COUNTS = 6;

   // result kinds
   localparam logic KIND_EVENT  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // level and persistence limits
   localparam logic [15:0] NEUTRAL_LEVEL_LIMIT = 16'd700;
   localparam logic [15:0] TEMP_LEVEL_LIMIT    = 16'd1500;
   localparam logic [16:0] NEUTRAL_TIME_LIMIT  = 17'd3000;
   localparam logic [16:0] EARTH_TIME_LIMIT    = 17'd3000;
   localparam logic [16:0] TEMP_TIME_LIMIT     = 17'd120000;
   localparam logic [16:0] ESTOP_TIME_LIMIT    = 17'd100;
   localparam logic [16:0] PNC_TIME_LIMIT      = 17'd500 - 17'd1;
   localparam logic [16:0] LID_TIME_LIMIT      = 17'd1000;

   // result slots, in emission order
   localparam int NUM_SLOTS    = 8;
   localparam int SLOT_W       = $clog2(NUM_SLOTS);
   localparam int SLOT_LEAK    = 0;
   localparam int SLOT_NEUT_A  = 1;
   localparam int SLOT_NEUT_D  = 2;
   localparam int SLOT_EARTH   = 3;
   localparam int SLOT_TEMP    = 4;
   localparam int SLOT_ESTOP   = 5;
   localparam int SLOT_LID     = 6;
   localparam int SLOT_STATUS  = 7;

   typedef struct packed {
      logic [8:0]  channel_enable;
      logic [15:0] leak_baseline;
      logic [15:0] leak_threshold;
      logic [15:0] earth_threshold;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  period;
      logic [15:0] leak_level;
      logic [15:0] neutral_level;
      logic        neutral_contact;
      logic [15:0] earth_level;
      logic [15:0] temp_level;
      logic        estop_contact;
      logic        pnc_contact;
      logic        lid_contact;
   } item_type;

   typedef struct packed {
      logic [6:0]                        alarm_active;
      logic [11:0]                       neutral_timer;
      logic [11:0]                       earth_timer;
      logic [16:0]                       temp_timer;
      logic [8:0]                        estop_timer;
      logic [9:0]                        pnc_timer;
      logic [10:0]                       lid_timer;
      logic [NUM_COUNTS-1:0][15:0]       raise_counts;
   } state_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  channel;
      logic        raised;
      logic [15:0] alarm_count;
      logic [6:0]  alarm_flags;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]             vld;
      result_type [NUM_SLOTS-1:0]       ent;
   } list_type;

   typedef struct packed {
      logic [16:0] timer;
      logic        raise;
      logic        clear;
   } timed_type;

   // one persistence step of a timed channel
   function automatic timed_type timed_step(input logic fault, input logic active,
                                            input logic [16:0] timer,
                                            input logic [16:0] limit,
                                            input logic hold_clears,
                                            input logic [7:0] period);
      timed_type r;
      r.timer = timer;
      r.raise = 1'b0;
      r.clear = 1'b0;
      if (fault) begin
         if (active) begin
            if (hold_clears) begin
               r.timer = '0;
            end
         end else if (timer <= limit) begin
            r.timer = timer + {9'd0, period};
         end else begin
            r.raise = 1'b1;
         end
      end else begin
         r.timer = '0;
         r.clear = active;
      end
      return r;
   endfunction

   function automatic result_type make_event(input logic [2:0] ch, input logic raised,
                                             input logic [15:0] cnt,
                                             input logic [6:0] flags);
      result_type r;
      r.kind        = KIND_EVENT;
      r.channel     = ch;
      r.raised      = raised;
      r.alarm_count = cnt;
      r.alarm_flags = flags;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

>>> rtl/sfaq_eval.sv
module sfaq_eval (
   input  sfaq_pkg::cfg_type   cfg,
   input  sfaq_pkg::item_type  item,
   input  sfaq_pkg::state_type state_cur,
   output sfaq_pkg::state_type state_next,
   output sfaq_pkg::list_type  list
);
   import sfaq_pkg::*;

   logic [15:0] leak_dev;
   logic        leak_fault;
   timed_type   t_na, t_nd, t_ea, t_te, t_es, t_pn, t_li;
   logic [6:0]  flags;
   logic [NUM_COUNTS-1:0][15:0] counts;

   always_comb begin
      leak_dev = (item.leak_level >= cfg.leak_baseline) ?
                 item.leak_level - cfg.leak_baseline :
                 cfg.leak_baseline - item.leak_level;
      leak_fault = leak_dev > cfg.leak_threshold;

      state_next = state_cur;
      flags      = state_cur.alarm_active;
      counts     = state_cur.raise_counts;
      list       = '0;
      t_na = '0; t_nd = '0; t_ea = '0; t_te = '0; t_es = '0; t_pn = '0; t_li = '0;

      // leakage, no persistence
      if (cfg.channel_enable[EN_LEAK]) begin
         if (leak_fault && !flags[FLAG_LEAK]) begin
            flags[FLAG_LEAK] = 1'b1;
            counts[CH_LEAK]  = counts[CH_LEAK] + 16'd1;
            list.vld[SLOT_LEAK] = 1'b1;
            list.ent[SLOT_LEAK] = make_event(CH_LEAK, 1'b1, counts[CH_LEAK], flags);
         end else if (!leak_fault && flags[FLAG_LEAK]) begin
            flags[FLAG_LEAK] = 1'b0;
            list.vld[SLOT_LEAK] = 1'b1;
            list.ent[SLOT_LEAK] = make_event(CH_LEAK, 1'b0, counts[CH_LEAK], flags);
         end
      end

      // neutral analog check
      if (cfg.channel_enable[EN_NEUTRAL] && cfg.channel_enable[EN_NEUT_ANA]) begin
         t_na = timed_step(item.neutral_level > NEUTRAL_LEVEL_LIMIT, flags[FLAG_NEUTRAL],
                           {5'd0, state_next.neutral_timer}, NEUTRAL_TIME_LIMIT, 1'b0,
                           item.period);
         state_next.neutral_timer = t_na.timer[11:0];
         if (t_na.raise) begin
            flags[FLAG_NEUTRAL] = 1'b1;
            counts[CH_NEUTRAL]  = counts[CH_NEUTRAL] + 16'd1;
         end else if (t_na.clear) begin
            flags[FLAG_NEUTRAL] = 1'b0;
         end
         list.vld[SLOT_NEUT_A] = t_na.raise | t_na.clear;
         list.ent[SLOT_NEUT_A] = make_event(CH_NEUTRAL, t_na.raise, counts[CH_NEUTRAL], flags);
      end

      // neutral digital check, same timer and alarm
      if (cfg.channel_enable[EN_NEUTRAL] && cfg.channel_enable[EN_NEUT_DIG]) begin
         t_nd = timed_step(!item.neutral_contact, flags[FLAG_NEUTRAL],
                           {5'd0, state_next.neutral_timer}, NEUTRAL_TIME_LIMIT, 1'b0,
                           item.period);
         state_next.neutral_timer = t_nd.timer[11:0];
         if (t_nd.raise) begin
            flags[FLAG_NEUTRAL] = 1'b1;
            counts[CH_NEUTRAL]  = counts[CH_NEUTRAL] + 16'd1;
         end else if (t_nd.clear) begin
            flags[FLAG_NEUTRAL] = 1'b0;
         end
         list.vld[SLOT_NEUT_D] = t_nd.raise | t_nd.clear;
         list.ent[SLOT_NEUT_D] = make_event(CH_NEUTRAL, t_nd.raise, counts[CH_NEUTRAL], flags);
      end

      // protective earth
      if (cfg.channel_enable[EN_EARTH]) begin
         t_ea = timed_step(item.earth_level > cfg.earth_threshold, flags[FLAG_EARTH],
                           {5'd0, state_cur.earth_timer}, EARTH_TIME_LIMIT, 1'b0,
                           item.period);
         state_next.earth_timer = t_ea.timer[11:0];
         if (t_ea.raise) begin
            flags[FLAG_EARTH] = 1'b1;
            counts[CH_EARTH]  = counts[CH_EARTH] + 16'd1;
         end else if (t_ea.clear) begin
            flags[FLAG_EARTH] = 1'b0;
         end
         list.vld[SLOT_EARTH] = t_ea.raise | t_ea.clear;
         list.ent[SLOT_EARTH] = make_event(CH_EARTH, t_ea.raise, counts[CH_EARTH], flags);
      end

      // ambient temperature
      if (cfg.channel_enable[EN_TEMP]) begin
         t_te = timed_step(item.temp_level > TEMP_LEVEL_LIMIT, flags[FLAG_TEMP],
                           state_cur.temp_timer, TEMP_TIME_LIMIT, 1'b1, item.period);
         state_next.temp_timer = t_te.timer;
         if (t_te.raise) begin
            flags[FLAG_TEMP] = 1'b1;
            counts[CH_TEMP]  = counts[CH_TEMP] + 16'd1;
         end else if (t_te.clear) begin
            flags[FLAG_TEMP] = 1'b0;
         end
         list.vld[SLOT_TEMP] = t_te.raise | t_te.clear;
         list.ent[SLOT_TEMP] = make_event(CH_TEMP, t_te.raise, counts[CH_TEMP], flags);
      end

      // emergency stop
      if (cfg.channel_enable[EN_ESTOP]) begin
         t_es = timed_step(item.estop_contact, flags[FLAG_ESTOP],
                           {8'd0, state_cur.estop_timer}, ESTOP_TIME_LIMIT, 1'b1,
                           item.period);
         state_next.estop_timer = t_es.timer[8:0];
         if (t_es.raise) begin
            flags[FLAG_ESTOP] = 1'b1;
            counts[CH_ESTOP]  = counts[CH_ESTOP] + 16'd1;
         end else if (t_es.clear) begin
            flags[FLAG_ESTOP] = 1'b0;
         end
         list.vld[SLOT_ESTOP] = t_es.raise | t_es.clear;
         list.ent[SLOT_ESTOP] = make_event(CH_ESTOP, t_es.raise, counts[CH_ESTOP], flags);
      end

      // pnc: alarm bit and timer only, no event
      if (cfg.channel_enable[EN_PNC]) begin
         t_pn = timed_step(item.pnc_contact, flags[FLAG_PNC],
                           {7'd0, state_cur.pnc_timer}, PNC_TIME_LIMIT, 1'b1, item.period);
         state_next.pnc_timer = t_pn.timer[9:0];
         if (t_pn.raise) begin
            flags[FLAG_PNC] = 1'b1;
         end else if (t_pn.clear) begin
            flags[FLAG_PNC] = 1'b0;
         end
      end

      // open lid
      if (cfg.channel_enable[EN_LID]) begin
         t_li = timed_step(!item.lid_contact, flags[FLAG_LID],
                           {6'd0, state_cur.lid_timer}, LID_TIME_LIMIT, 1'b1, item.period);
         state_next.lid_timer = t_li.timer[10:0];
         if (t_li.raise) begin
            flags[FLAG_LID] = 1'b1;
            counts[CH_LID]  = counts[CH_LID] + 16'd1;
         end else if (t_li.clear) begin
            flags[FLAG_LID] = 1'b0;
         end
         list.vld[SLOT_LID] = t_li.raise | t_li.clear;
         list.ent[SLOT_LID] = make_event(CH_LID, t_li.raise, counts[CH_LID], flags);
      end

      // end-of-tick status
      list.vld[SLOT_STATUS]             = 1'b1;
      list.ent[SLOT_STATUS].kind        = KIND_STATUS;
      list.ent[SLOT_STATUS].channel     = CH_LEAK;
      list.ent[SLOT_STATUS].raised      = 1'b0;
      list.ent[SLOT_STATUS].alarm_count = '0;
      list.ent[SLOT_STATUS].alarm_flags = flags;
      list.ent[SLOT_STATUS].last        = 1'b1;

      state_next.alarm_active = flags;
      state_next.raise_counts = counts;
   end

endmodule

>>> rtl/sfaq_emit.sv
module sfaq_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  sfaq_pkg::list_type   list,
   output logic                 load_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sfaq_pkg::result_type rsp_data
);
   import sfaq_pkg::*;

   logic [NUM_SLOTS-1:0]       buf_vld_ff, buf_vld_in;
   result_type [NUM_SLOTS-1:0] buf_ent_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   result_type                 rsp_data_ff;
   logic [SLOT_W-1:0]          pick;
   logic                       found;
   logic                       pending;
   logic                       single;
   logic                       move;

   // lowest pending slot goes out first
   always_comb begin
      pick  = '0;
      found = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (buf_vld_ff[i] && !found) begin
            pick  = SLOT_W'(i);
            found = 1'b1;
         end
      end
   end

   always_comb begin
      pending    = |buf_vld_ff;
      single     = ((buf_vld_ff & (buf_vld_ff - NUM_SLOTS'(1))) == '0);
      move       = pending && (!rsp_valid_ff || rsp_ready);
      load_ready = !pending || (move && single);

      buf_vld_in = buf_vld_ff;
      if (move) begin
         buf_vld_in[pick] = 1'b0;
      end
      if (load) begin
         buf_vld_in = list.vld;
      end

      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_vld_ff   <= buf_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ent_ff <= list.ent;
      end
      if (move) begin
         rsp_data_ff <= buf_ent_ff[pick];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/sensor_fault_alarm_qualifier_unit.sv
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   one monitoring tick (period + readings)
// rsp       out        rsp_valid / rsp_ready   alarm event or end-of-tick status
// csr       in         csr_write_enable        csr_index, csr_write_data (no read-back)
//
// a tick gives one result per cycle while rsp_ready is high, 1 to 8 results,
// always ending with status; the result serializer sets the rate
// an accepted tick passes the input register, result list buffer and output register
// status-only ticks are taken back to back, one per cycle while rsp_ready is high
// reset clears config, alarms, timers, raise counts and all valid flags
// rsp stalls hold the output register; req_ready drops once the input register backs up
module sensor_fault_alarm_qualifier_unit (
   input  logic        clock,
   input  logic        reset,
   // tick input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_period,
   input  logic [15:0] req_leak_level,
   input  logic [15:0] req_neutral_level,
   input  logic        req_neutral_contact,
   input  logic [15:0] req_earth_level,
   input  logic [15:0] req_temp_level,
   input  logic        req_estop_contact,
   input  logic        req_pnc_contact,
   input  logic        req_lid_contact,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [2:0]  rsp_channel,
   output logic        rsp_raised,
   output logic [15:0] rsp_alarm_count,
   output logic [6:0]  rsp_alarm_flags,
   output logic        rsp_last,
   // configuration writes
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import sfaq_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   item_ff;
   logic       item_vld_ff, item_vld_in;
   state_type  state_ff, state_in;
   state_type  state_next_w;
   list_type   list;
   result_type rsp_data;
   logic       load;
   logic       load_ready;
   logic       req_take;

   // configuration registers, out-of-range indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_CHANNEL_ENABLE:  cfg_in.channel_enable  = csr_write_data[8:0];
            REG_LEAK_BASELINE:   cfg_in.leak_baseline   = csr_write_data;
            REG_LEAK_THRESHOLD:  cfg_in.leak_threshold  = csr_write_data;
            REG_EARTH_THRESHOLD: cfg_in.earth_threshold = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // input register: a tick moves on once the result list has room
   assign load      = item_vld_ff && load_ready;
   assign req_ready = !item_vld_ff || load_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      item_vld_in = item_vld_ff;
      if (req_take) begin
         item_vld_in = 1'b1;
      end else if (load) begin
         item_vld_in = 1'b0;
      end
      // channel state advances only when the tick is qualified
      state_in = load ? state_next_w : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         item_vld_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         cfg_ff      <= cfg_in;
         item_vld_ff <= item_vld_in;
         state_ff    <= state_in;
      end
   end

   // tick payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.period          <= req_period;
         item_ff.leak_level      <= req_leak_level;
         item_ff.neutral_level   <= req_neutral_level;
         item_ff.neutral_contact <= req_neutral_contact;
         item_ff.earth_level     <= req_earth_level;
         item_ff.temp_level      <= req_temp_level;
         item_ff.estop_contact   <= req_estop_contact;
         item_ff.pnc_contact     <= req_pnc_contact;
         item_ff.lid_contact     <= req_lid_contact;
      end
   end

   // all channels qualified in one pass, giving the ordered result list
   sfaq_eval u_eval (
      .cfg        (cfg_ff),
      .item       (item_ff),
      .state_cur  (state_ff),
      .state_next (state_next_w),
      .list       (list)
   );

   // result list buffer and output register
   sfaq_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .list       (list),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_channel     = rsp_data.channel;
   assign rsp_raised      = rsp_data.raised;
   assign rsp_alarm_count = rsp_data.alarm_count;
   assign rsp_alarm_flags = rsp_data.alarm_flags;
   assign rsp_last        = rsp_data.last;

endmodule

>>> rtl/sfaq_checker.sv
`include "sensor_fault_alarm_qualifier_unit_macros.svh"

module sfaq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [2:0]  rsp_channel,
   input logic        rsp_raised,
   input logic [15:0] rsp_alarm_count,
   input logic [6:0]  rsp_alarm_flags,
   input logic        rsp_last
);
   import sfaq_pkg::*;

   // a stalled transaction holds its payload
   `SFAQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_kind, rsp_channel, rsp_raised, rsp_alarm_count, rsp_alarm_flags, rsp_last}))

   // only the status result closes a tick
   `SFAQ_ASSERT_IMPLY(a_last_is_status, clock, reset, rsp_valid, rsp_last == (rsp_kind == KIND_STATUS))

   // status carries no channel, edge or count
   `SFAQ_ASSERT_IMPLY(a_status_clean, clock, reset, rsp_valid && rsp_kind == KIND_STATUS, rsp_channel == CH_LEAK && !rsp_raised && rsp_alarm_count == 16'd0)

   // a raise or clear shows the new alarm bit of its channel
   `SFAQ_ASSERT_IMPLY(a_event_flag, clock, reset, rsp_valid && rsp_kind == KIND_EVENT, (rsp_channel == CH_LEAK && rsp_alarm_flags[FLAG_LEAK] == rsp_raised) || (rsp_channel == CH_NEUTRAL && rsp_alarm_flags[FLAG_NEUTRAL] == rsp_raised) || (rsp_channel == CH_EARTH && rsp_alarm_flags[FLAG_EARTH] == rsp_raised) || (rsp_channel == CH_TEMP && rsp_alarm_flags[FLAG_TEMP] == rsp_raised) || (rsp_channel == CH_ESTOP && rsp_alarm_flags[FLAG_ESTOP] == rsp_raised) || (rsp_channel == CH_LID && rsp_alarm_flags[FLAG_LID] == rsp_raised))

   // nothing comes out right after reset
   `SFAQ_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind sensor_fault_alarm_qualifier_unit sfaq_checker u_sfaq_checker (.*);
